// ===== src/tbps_pkg.sv =====
// shared types and constants for the tick budget priority scheduler
`timescale 1ns / 1ps

package tbps_pkg;

	// slot geometry
	localparam int TASK_SLOTS = 8;
	localparam int SLOT_W     = 3;
	localparam int BUDGET_W   = 8;
	localparam int COUNT_W    = 4;
	localparam int PRIO_W     = TASK_SLOTS * BUDGET_W;
	localparam int CFG_IDX_W  = 2;

	// item kinds
	localparam logic [1:0] KIND_SCHED = 2'd0;
	localparam logic [1:0] KIND_BLOCK = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRIORITY   = 2'd1;

	// running maximum handed from cell to cell during a scan
	typedef struct packed {
		logic                valid;
		logic                found;
		logic [BUDGET_W-1:0] best;
		logic [SLOT_W-1:0]   idx;
	} link_t;

	// per-item controls broadcast to every cell
	typedef struct packed {
		logic              dec_en;
		logic [SLOT_W-1:0] running;
		logic              blk_we;
		logic [SLOT_W-1:0] blk_slot;
		logic              blk_val;
		logic              reload;
	} cell_ctrl_t;

endpackage

// ===== src/tbps_cell.sv =====
// one task slot: budget and blocked flag, plus one stage of the max scan chain
`timescale 1ns / 1ps

module tbps_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tbps_pkg::SLOT_W-1:0]   my_idx,
	input  logic                          active,
	input  logic [tbps_pkg::BUDGET_W-1:0] prio,
	input  tbps_pkg::cell_ctrl_t          ctrl,
	input  tbps_pkg::link_t               lin,
	output tbps_pkg::link_t               lout,
	output logic                          budget_nz,
	output logic                          blocked
);

	logic [tbps_pkg::BUDGET_W-1:0] budget_q;
	logic                          blocked_q;
	logic                          take;
	logic                          lvalid_q;
	logic                          lfound_q;
	logic [tbps_pkg::BUDGET_W-1:0] lbest_q;
	logic [tbps_pkg::SLOT_W-1:0]   lidx_q;

	assign budget_nz = (budget_q != '0);
	assign blocked   = blocked_q;

	// budget: refill from priority, or lose one tick while running
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
		end else if (ctrl.reload && active && !blocked_q) begin
			budget_q <= prio;
		end else if (ctrl.dec_en && ctrl.running == my_idx && budget_nz) begin
			budget_q <= budget_q - tbps_pkg::BUDGET_W'(1);
		end
	end

	// blocked flag write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q <= 1'b0;
		end else if (ctrl.blk_we && ctrl.blk_slot == my_idx) begin
			blocked_q <= ctrl.blk_val;
		end
	end

	// strictly larger wins, so ties stay with the lower slot
	assign take = active && !blocked_q && (budget_q > lin.best);

	// scan token valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvalid_q <= 1'b0;
		end else begin
			lvalid_q <= lin.valid;
		end
	end

	// running maximum payload
	always_ff @(posedge clk) begin
		lfound_q <= take ? 1'b1 : lin.found;
		lbest_q  <= take ? budget_q : lin.best;
		lidx_q   <= take ? my_idx : lin.idx;
	end

	assign lout.valid = lvalid_q;
	assign lout.found = lfound_q;
	assign lout.best  = lbest_q;
	assign lout.idx   = lidx_q;

endmodule

// ===== src/tick_budget_priority_scheduler.sv =====
// top level: item handshake, sequencer, configuration and the row of slot cells
`timescale 1ns / 1ps

// Each slot cell holds one task's tick budget and blocked flag; picks are made by a
// running-maximum token that walks the eight cells, one cell per clock. Set-blocked,
// tick and ignored items, and a schedule that keeps the running task, go from the
// transfer to the result register and then to the output register. A schedule that
// picks anew waits for one full walk of the chain; one that must refill budgets
// first does a walk, a refill and a second walk. A new item is taken only once the
// previous one has its result registered; a result may wait at the output while
// the next item is already being worked on. Configuration writes are always ready.
module tick_budget_priority_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tbps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tbps_pkg::PRIO_W-1:0]         cfg_data,
	// item input
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          kind,
	input  logic [tbps_pkg::SLOT_W-1:0]         slot,
	input  logic                                blocked,
	// result output
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tbps_pkg::SLOT_W-1:0]         current_task,
	output logic                                switched,
	output logic                                reloaded,
	output logic                                none_ready
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN1  = 3'd1;
	localparam logic [2:0] ST_RELOAD = 3'd2;
	localparam logic [2:0] ST_RELNCH = 3'd3;
	localparam logic [2:0] ST_SCAN2  = 3'd4;
	localparam logic [2:0] ST_RESP   = 3'd5;

	logic [2:0]                            state_q;
	logic [2:0]                            state_d;
	logic [tbps_pkg::COUNT_W-1:0]          task_count_q;
	logic [tbps_pkg::PRIO_W-1:0]           priority_q;
	logic [tbps_pkg::SLOT_W-1:0]           running_q;
	logic [tbps_pkg::SLOT_W-1:0]           running_d;
	logic [tbps_pkg::SLOT_W-1:0]           res_task_q;
	logic                                  res_sw_q;
	logic                                  res_rl_q;
	logic                                  res_nr_q;
	logic                                  res_load;
	logic [tbps_pkg::SLOT_W-1:0]           res_task_d;
	logic                                  res_sw_d;
	logic                                  res_rl_d;
	logic                                  res_nr_d;
	logic                                  out_valid_q;
	logic [tbps_pkg::SLOT_W-1:0]           out_task_q;
	logic                                  out_sw_q;
	logic                                  out_rl_q;
	logic                                  out_nr_q;
	logic                                  in_xfer;
	logic                                  out_free;
	logic                                  keep;
	logic                                  launch;
	logic [tbps_pkg::TASK_SLOTS-1:0]       active;
	logic [tbps_pkg::TASK_SLOTS-1:0]       nz_vec;
	logic [tbps_pkg::TASK_SLOTS-1:0]       blk_vec;
	logic [tbps_pkg::TASK_SLOTS:0]         link_vld;
	tbps_pkg::cell_ctrl_t                  ctrl;
	tbps_pkg::link_t                       links [tbps_pkg::TASK_SLOTS+1];
	tbps_pkg::link_t                       tail;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			priority_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == tbps_pkg::REG_TASK_COUNT) begin
				task_count_q <= cfg_data[tbps_pkg::COUNT_W-1:0];
			end else if (cfg_index == tbps_pkg::REG_PRIORITY) begin
				priority_q <= cfg_data;
			end
		end
	end

	// handshake
	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// keep test on the running task
	assign keep = nz_vec[running_q] && !blk_vec[running_q];

	// start a scan on a schedule that cannot keep, or after a refill
	assign launch = (in_xfer && kind == tbps_pkg::KIND_SCHED && !keep)
		|| (state_q == ST_RELNCH);

	// controls broadcast to the cells
	always_comb begin
		ctrl.dec_en   = in_xfer && kind == tbps_pkg::KIND_TICK;
		ctrl.running  = running_q;
		ctrl.blk_we   = in_xfer && kind == tbps_pkg::KIND_BLOCK;
		ctrl.blk_slot = slot;
		ctrl.blk_val  = blocked;
		ctrl.reload   = (state_q == ST_RELOAD);
	end

	// chain head: empty maximum
	always_comb begin
		links[0].valid = launch;
		links[0].found = 1'b0;
		links[0].best  = '0;
		links[0].idx   = '0;
	end

	// row of slot cells
	for (genvar i = 0; i < tbps_pkg::TASK_SLOTS; i++) begin : g_cell
		assign active[i] = (tbps_pkg::COUNT_W'(i) < task_count_q);

		tbps_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.my_idx    (tbps_pkg::SLOT_W'(i)),
			.active    (active[i]),
			.prio      (priority_q[tbps_pkg::BUDGET_W*i +: tbps_pkg::BUDGET_W]),
			.ctrl      (ctrl),
			.lin       (links[i]),
			.lout      (links[i+1]),
			.budget_nz (nz_vec[i]),
			.blocked   (blk_vec[i])
		);
	end

	for (genvar j = 0; j <= tbps_pkg::TASK_SLOTS; j++) begin : g_vld
		assign link_vld[j] = links[j].valid;
	end

	assign tail = links[tbps_pkg::TASK_SLOTS];

	// sequencer
	always_comb begin
		state_d    = state_q;
		running_d  = running_q;
		res_load   = 1'b0;
		res_task_d = running_q;
		res_sw_d   = 1'b0;
		res_rl_d   = 1'b0;
		res_nr_d   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (kind == tbps_pkg::KIND_SCHED && !keep) begin
						state_d = ST_SCAN1;
					end else begin
						res_load = 1'b1;
						state_d  = ST_RESP;
					end
				end
			end
			ST_SCAN1: begin
				if (tail.valid) begin
					if (tail.found) begin
						running_d  = tail.idx;
						res_load   = 1'b1;
						res_task_d = tail.idx;
						res_sw_d   = (tail.idx != running_q);
						state_d    = ST_RESP;
					end else begin
						state_d = ST_RELOAD;
					end
				end
			end
			ST_RELOAD: begin
				state_d = ST_RELNCH;
			end
			ST_RELNCH: begin
				state_d = ST_SCAN2;
			end
			ST_SCAN2: begin
				if (tail.valid) begin
					res_load = 1'b1;
					res_rl_d = 1'b1;
					if (tail.found) begin
						running_d  = tail.idx;
						res_task_d = tail.idx;
						res_sw_d   = (tail.idx != running_q);
					end else begin
						res_nr_d = 1'b1;
					end
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer state and running task
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			running_q <= '0;
		end else begin
			state_q   <= state_d;
			running_q <= running_d;
		end
	end

	// finished result waiting for the output register
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_task_q <= res_task_d;
			res_sw_q   <= res_sw_d;
			res_rl_q   <= res_rl_d;
			res_nr_q   <= res_nr_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			out_task_q <= res_task_q;
			out_sw_q   <= res_sw_q;
			out_rl_q   <= res_rl_q;
			out_nr_q   <= res_nr_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign current_task = out_task_q;
	assign switched     = out_sw_q;
	assign reloaded     = out_rl_q;
	assign none_ready   = out_nr_q;

	// only one scan token in the chain at a time
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(link_vld))
		else $error("more than one scan token in the cell chain");

	// the token leaves the chain only while a scan is awaited
	assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> (state_q == ST_SCAN1 || state_q == ST_SCAN2))
		else $error("scan token reached the chain end outside a scan");

	// an accepted item always makes the sequencer busy
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q != ST_IDLE))
		else $error("item transfer did not start work");

	// none_ready is reported only after a refill
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && none_ready) |-> reloaded)
		else $error("none_ready reported without a refill");

endmodule
